// File: hw/rtl/dpq_pkg.sv
// dpq_pkg: shared types and constants for the double-ended priority queue
// no dependencies; used by dpq_cell and double_ended_priority_queue
package dpq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned KindW        = 2;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned EntryCountW  = 5;

  // value returned by a pop on an empty queue
  localparam logic signed [ValueW-1:0] EmptyValue = -32'sd1;

  typedef enum logic [KindW-1:0] {
    KindPush   = 2'd0,
    KindPopMax = 2'd1,
    KindPopMin = 2'd2,
    KindNop    = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // one stored entry of the chain
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] val;
    logic signed [ValueW-1:0] prio;
  } entry_t;

  // command broadcast to every cell in a cycle
  typedef struct packed {
    logic                     push;
    logic                     pop_max;
    logic                     pop_min;
    logic signed [ValueW-1:0] val;
    logic signed [ValueW-1:0] prio;
  } cmd_t;

endpackage

// File: hw/rtl/dpq_cell.sv
// dpq_cell: one slot of the sorted shift-register chain
// depends on dpq_pkg (entry_t, cmd_t)
module dpq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dpq_pkg::cmd_t   cmd_i,
  input  dpq_pkg::entry_t left_i,
  input  logic            left_ge_i,
  input  dpq_pkg::entry_t right_i,
  output dpq_pkg::entry_t entry_o,
  output logic            ge_o,
  output logic [dpq_pkg::ValueW-1:0] tail_value_o
);
  import dpq_pkg::*;

  logic   valid_q, valid_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic signed [ValueW-1:0] prio_q, prio_d;

  // held entry stays ahead of an incoming one of lower or equal priority
  assign ge_o = valid_q && ($signed(prio_q) >= $signed(cmd_i.prio));

  assign entry_o = '{valid: valid_q, val: val_q, prio: prio_q};

  // last valid cell drives the tail value, all others drive zero
  assign tail_value_o = (valid_q && !right_i.valid) ? val_q : '0;

  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    prio_d  = prio_q;
    if (cmd_i.push) begin
      if (!ge_o) begin
        if (left_ge_i) begin
          valid_d = 1'b1;
          val_d   = cmd_i.val;
          prio_d  = cmd_i.prio;
        end else begin
          valid_d = left_i.valid;
          val_d   = left_i.val;
          prio_d  = left_i.prio;
        end
      end
    end else if (cmd_i.pop_max) begin
      valid_d = right_i.valid;
      val_d   = right_i.val;
      prio_d  = right_i.prio;
    end else if (cmd_i.pop_min) begin
      valid_d = valid_q && right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    prio_q <= prio_d;
  end

endmodule

// File: hw/rtl/double_ended_priority_queue.sv
// double_ended_priority_queue: bounded queue sorted by priority, highest first
// the result of a transaction is registered and strobed on done_o in the cycle after start_i
// throughput: one transaction per cycle, as the whole cell chain updates together
// busy_o stays low; the receiver cannot stall, each result shows for exactly one cycle
// reset: asynchronous active-low rst_ni empties the queue; stored data is not cleared
// depends on dpq_pkg and dpq_cell
module double_ended_priority_queue #(
  parameter int unsigned DEPTH = dpq_pkg::DepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [dpq_pkg::KindW-1:0]          kind_i,
  input  logic signed [dpq_pkg::ValueW-1:0]  item_value_i,
  input  logic signed [dpq_pkg::ValueW-1:0]  item_priority_i,
  output logic                               done_o,
  output logic signed [dpq_pkg::ValueW-1:0]  popped_value_o,
  output logic [dpq_pkg::StatusW-1:0]        status_o,
  output logic [dpq_pkg::EntryCountW-1:0]    entry_count_o
);
  import dpq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // chain state, one entry per cell
  entry_t entries [DEPTH];
  logic   ge      [DEPTH];
  logic [ValueW-1:0] tail_vals [DEPTH];

  cmd_t   cmd;
  logic   full, empty;
  logic [ValueW-1:0] tail_value;

  // occupancy counter and registered result
  logic [CntW-1:0]          occ_q, occ_d;
  logic                     done_q;
  logic signed [ValueW-1:0] result_q, result_d;
  status_e                  status_q, status_d;

  kind_e kind;
  assign kind = kind_e'(kind_i);

  // the chain takes a transaction every cycle
  assign busy_o = 1'b0;

  // sorted chain: head in cell 0, valid cells always form a prefix
  assign full  = entries[DEPTH-1].valid;
  assign empty = !entries[0].valid;

  // only one cell drives a nonzero tail value, so an or-reduce selects it
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_value = tail_value | tail_vals[i];
    end
  end

  // decode the transaction into a chain command and the result
  always_comb begin
    cmd         = '0;
    cmd.val     = item_value_i;
    cmd.prio    = item_priority_i;
    occ_d       = occ_q;
    result_d    = '0;
    status_d    = StOk;
    if (start_i) begin
      case (kind)
        KindPush: begin
          if (full) begin
            status_d = StFull;
          end else begin
            cmd.push = 1'b1;
            occ_d    = occ_q + CntW'(1);
          end
        end
        KindPopMax: begin
          if (empty) begin
            result_d = EmptyValue;
            status_d = StEmpty;
          end else begin
            cmd.pop_max = 1'b1;
            result_d    = entries[0].val;
            occ_d       = occ_q - CntW'(1);
          end
        end
        KindPopMin: begin
          if (empty) begin
            result_d = EmptyValue;
            status_d = StEmpty;
          end else begin
            cmd.pop_min = 1'b1;
            result_d    = $signed(tail_value);
            occ_d       = occ_q - CntW'(1);
          end
        end
        default: begin
          // unused kind: no change, ok status, zero value
        end
      endcase
    end
  end

  // cell chain; cell 0 sees a virtual left neighbor that always ranks ahead
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_ge;

    if (i == 0) begin : g_head
      assign left_entry = '{valid: 1'b1, val: '0, prio: '0};
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_ge    = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_next
      assign right_entry = entries[i+1];
    end

    dpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (left_entry),
      .left_ge_i    (left_ge),
      .right_i      (right_entry),
      .entry_o      (entries[i]),
      .ge_o         (ge[i]),
      .tail_value_o (tail_vals[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      done_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      done_q <= start_i;
    end
  end

  // result payload needs no reset, it is qualified by done_o
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    status_q <= status_d;
  end

  assign done_o         = done_q;
  assign popped_value_o = result_q;
  assign status_o       = status_q;

  // entry count is reported modulo the five-bit field
  if (CntW >= EntryCountW) begin : g_cnt_trunc
    assign entry_count_o = occ_q[EntryCountW-1:0];
  end else begin : g_cnt_ext
    assign entry_count_o = {{(EntryCountW - CntW){1'b0}}, occ_q};
  end

endmodule

// File: dv/tb_double_ended_priority_queue.sv
// tb_double_ended_priority_queue: self-checking testbench for the priority queue
// depends on dpq_pkg and the double_ended_priority_queue rtl; a shadow model
// in a small class predicts each result, plain tasks drive the command port

module tb_double_ended_priority_queue;
  import dpq_pkg::*;

  localparam int unsigned QueueDepth   = DepthDefault;
  localparam int unsigned RandomItems  = 1000;
  // the last part of the run goes without any idling
  localparam int unsigned BusyTailFrom = 850;
  // longest legal quiet stretch is the longest hold_off gap plus the wait for one result
  localparam int unsigned StallLimit   = 200;
  localparam int unsigned MaxReported  = 10;

  // one expected result: what a transaction should return
  typedef struct {
    logic signed [ValueW-1:0] value;
    status_e                  status;
    logic [EntryCountW-1:0]   count;
  } queue_result_t;

  // shadow copy of the queue plus the list of results still owed by the block
  class dpq_shadow;
    logic signed [ValueW-1:0] held_values [QueueDepth];
    logic signed [ValueW-1:0] held_prios  [QueueDepth];
    int unsigned              held_count = 0;
    queue_result_t            owed_results[$];
    int unsigned              failures = 0;
    int unsigned              checked = 0;
    int unsigned              full_drops = 0;
    int unsigned              empty_pops = 0;
    int unsigned              transactions = 0;

    // work out what an accepted transaction must return and update the shadow
    function void note_transaction(kind_e kind, logic signed [ValueW-1:0] val,
                                   logic signed [ValueW-1:0] prio);
      queue_result_t res;
      int unsigned   pos;
      res.value  = '0;
      res.status = StOk;
      transactions++;
      case (kind)
        KindPush: begin
          if (held_count >= QueueDepth) begin
            res.status = StFull;
            full_drops++;
          end else begin
            // new entry lands behind every entry of greater or equal priority
            pos = 0;
            while (pos < held_count && held_prios[pos] >= prio) pos++;
            for (int unsigned i = held_count; i > pos; i--) begin
              held_values[i] = held_values[i-1];
              held_prios[i]  = held_prios[i-1];
            end
            held_values[pos] = val;
            held_prios[pos]  = prio;
            held_count++;
          end
        end
        KindPopMax: begin
          if (held_count == 0) begin
            res.value  = EmptyValue;
            res.status = StEmpty;
            empty_pops++;
          end else begin
            res.value = held_values[0];
            for (int unsigned i = 1; i < held_count; i++) begin
              held_values[i-1] = held_values[i];
              held_prios[i-1]  = held_prios[i];
            end
            held_count--;
          end
        end
        KindPopMin: begin
          if (held_count == 0) begin
            res.value  = EmptyValue;
            res.status = StEmpty;
            empty_pops++;
          end else begin
            held_count--;
            res.value = held_values[held_count];
          end
        end
        default: ;
      endcase
      res.count = held_count[EntryCountW-1:0];
      owed_results.push_back(res);
    endfunction

    function void report_failure(string what);
      if (failures < MaxReported) $display("mismatch: %s", what);
      failures++;
    endfunction

    // compare one strobed result against the oldest owed one
    function void check_result(logic signed [ValueW-1:0] value, logic [StatusW-1:0] status,
                               logic [EntryCountW-1:0] count);
      queue_result_t want;
      if (owed_results.size() == 0) begin
        report_failure($sformatf("result with nothing owed: value %0d status %0d count %0d",
                                 value, status, count));
        return;
      end
      want = owed_results.pop_front();
      checked++;
      if (value !== want.value)
        report_failure($sformatf("popped value expected %0d got %0d", want.value, value));
      if (status !== want.status)
        report_failure($sformatf("status expected %0d got %0d", want.status, status));
      if (count !== want.count)
        report_failure($sformatf("entry count expected %0d got %0d", want.count, count));
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [KindW-1:0]            kind_i;
  logic signed [ValueW-1:0]    item_value_i;
  logic signed [ValueW-1:0]    item_priority_i;
  logic                        done_o;
  logic signed [ValueW-1:0]    popped_value_o;
  logic [StatusW-1:0]          status_o;
  logic [EntryCountW-1:0]      entry_count_o;

  dpq_shadow   shadow = new();
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;

  double_ended_priority_queue #(
    .DEPTH(QueueDepth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .done_o         (done_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  // 20-unit clock period
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // monitor: inputs settle at the falling edge, so everything is sampled
  // at the rising edge; the transaction is noted before the result check
  // so the order works whatever the latency
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        shadow.note_transaction(kind_e'(kind_i), item_value_i, item_priority_i);
      if (done_o)
        shadow.check_result(popped_value_o, status_o, entry_count_o);
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("timeout after %0d quiet cycles", StallLimit);
        $display("double_ended_priority_queue regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // present one transaction and hold it until the block takes it;
  // start stays high when the next call follows straight away
  task automatic send_op(input kind_e kind, input logic signed [ValueW-1:0] val,
                         input logic signed [ValueW-1:0] prio);
    @(negedge clk_i);
    start_i         <= 1'b1;
    kind_i          <= kind;
    item_value_i    <= val;
    item_priority_i <= prio;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    items_sent++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // sender pause until every owed result has come back
  task automatic wait_for_drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (shadow.owed_results.size() != 0) @(posedge clk_i);
  endtask

  // mostly a narrow band so ties are common, plus full-range and extreme priorities
  function automatic logic signed [ValueW-1:0] pick_priority();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return $signed($urandom_range(6)) - 3;
    if (sel < 75) return $signed($urandom);
    case ($urandom_range(3))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return -32'sd1;
    endcase
  endfunction

  // one random phase: push_pct sets whether the queue tends to fill or drain
  task automatic random_phase(input int unsigned n_items, input int unsigned push_pct,
                              input int unsigned idle_pct);
    int unsigned sel;
    kind_e       kind;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (items_sent >= BusyTailFrom) idle_pct = 0;
      if ($urandom_range(99) < idle_pct) hold_off($urandom_range(15, 1));
      sel = $urandom_range(99);
      if (sel < 3)                 kind = KindNop;
      else if (sel < 3 + push_pct) kind = KindPush;
      else if (sel[0])             kind = KindPopMax;
      else                         kind = KindPopMin;
      send_op(kind, $signed($urandom), pick_priority());
    end
  endtask

  initial begin
    int unsigned push_pct;
    int unsigned idle_pct;

    rst_ni          = 1'b0;
    start_i         = 1'b0;
    kind_i          = KindNop;
    item_value_i    = '0;
    item_priority_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pops and a no-op on the empty queue
    send_op(KindPopMax, 32'sd11, 32'sd0);
    send_op(KindPopMin, 32'sd12, 32'sd0);
    send_op(KindNop, 32'sd13, 32'sd0);
    // extreme values and priorities, with ties at zero and at both ends
    send_op(KindPush, 32'sh7fff_ffff, 32'sd0);
    send_op(KindPush, 32'sh8000_0000, 32'sd0);
    send_op(KindPush, 32'sd0, 32'sh7fff_ffff);
    send_op(KindPush, -32'sd1, 32'sh8000_0000);
    send_op(KindPush, 32'sd1, -32'sd1);
    send_op(KindPush, 32'sd2, 32'sd0);
    send_op(KindPush, 32'sd3, 32'sh7fff_ffff);
    send_op(KindPush, 32'sd4, 32'sh8000_0000);
    // fill the rest of the queue with a repeating band of priorities
    for (int i = 0; i < 8; i++)
      send_op(KindPush, 32'sh5a5a_0000 + i, $signed(i % 3) - 1);
    // push into a full queue is dropped, then a no-op while full
    send_op(KindPush, 32'sd99, 32'sd5);
    send_op(KindNop, 32'sd0, 32'sd0);
    // take from both ends, including out of tie groups
    send_op(KindPopMax, 32'sd0, 32'sd0);
    send_op(KindPopMin, 32'sd0, 32'sd0);
    send_op(KindPopMax, 32'sd0, 32'sd0);
    send_op(KindPopMin, 32'sd0, 32'sd0);
    wait_for_drain();

    // random: phases that lean toward filling, draining or neither,
    // with varying idle rates and an occasional pause for all results
    items_sent = 0;
    while (items_sent < RandomItems) begin
      case ($urandom_range(2))
        0:       push_pct = 75;
        1:       push_pct = 20;
        default: push_pct = 48;
      endcase
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      random_phase($urandom_range(60, 10), push_pct, idle_pct);
      if ($urandom_range(5) == 0 && items_sent < BusyTailFrom) wait_for_drain();
    end

    // drain, then wait for any stray strobe
    wait_for_drain();
    repeat (4) @(posedge clk_i);
    if (shadow.owed_results.size() != 0)
      shadow.report_failure("results still owed at the end");

    $display("ran %0d transactions, checked %0d results", shadow.transactions,
             shadow.checked);
    $display("saw %0d dropped pushes on a full queue and %0d pops on an empty one",
             shadow.full_drops, shadow.empty_pops);
    if (shadow.failures == 0) begin
      $display("double_ended_priority_queue regression: pass");
    end else begin
      $display("%0d mismatches in total", shadow.failures);
      $display("double_ended_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dpq_pkg.sv
hw/rtl/dpq_cell.sv
hw/rtl/double_ended_priority_queue.sv
dv/tb_double_ended_priority_queue.sv
